@@ src/rlphd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rlphd_pkg;

	localparam int LEN_W = 32;
	localparam int ACC_W = 64;
	localparam int OFF_W = 4;
	localparam int WID_W = 4;

	localparam logic [7:0] SHORT_STR_BASE = 8'h80;
	localparam logic [7:0] SHORT_STR_LAST = 8'hb7;
	localparam logic [7:0] LONG_STR_LAST  = 8'hbf;
	localparam logic [7:0] SHORT_LST_BASE = 8'hc0;
	localparam logic [7:0] SHORT_LST_LAST = 8'hf7;
	localparam logic [ACC_W-1:0] CANON_MIN_LONG = ACC_W'(55);

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_LEN  = 2'd1,
		PH_BYTE = 2'd2
	} rlphd_phase_t;

	typedef struct packed {
		logic [7:0]       data_byte;
		logic             start_req;
		logic [LEN_W-1:0] avail_bytes;
	} rlphd_byte_t;

	typedef struct packed {
		logic             ok;
		logic             list_flag;
		logic             canonical_flag;
		logic [OFF_W-1:0] payload_offset;
		logic [LEN_W-1:0] payload_len;
		logic [LEN_W-1:0] total_len;
	} rlphd_result_t;

	typedef struct packed {
		logic          emit;
		rlphd_result_t res;
	} rlphd_step_t;

	// count of big-endian length bytes after a long-form header
	function automatic logic [WID_W-1:0] long_width(input logic [7:0] h);
		logic [7:0] w;
		begin
			w = (h > SHORT_LST_LAST) ? (h - SHORT_LST_LAST) : (h - SHORT_STR_LAST);
			long_width = w[WID_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

@@ src/rlphd_in_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rlphd_in_stage (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               byte_valid,
	output logic                    byte_ready,
	input  wire rlphd_pkg::rlphd_byte_t byte_item,
	input  wire logic               advance,
	output logic                    valid_s1,
	output rlphd_pkg::rlphd_byte_t  item_s1
);
	import rlphd_pkg::*;

	// take a new item when empty or whenever the held one drains this cycle
	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			item_s1 <= byte_item;
		end
	end

endmodule

`default_nettype wire

@@ src/rlphd_decode.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rlphd_decode #(
	parameter int AVAIL_BITS = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   step_en,
	input  wire rlphd_pkg::rlphd_byte_t item_s1,
	output rlphd_pkg::rlphd_step_t      step
);
	import rlphd_pkg::*;

	rlphd_phase_t           phase_q, phase_d;
	logic [7:0]             hdr_q, hdr_d;
	logic [WID_W-1:0]       left_q, left_d;
	logic [ACC_W-1:0]       acc_q, acc_d;
	logic                   lead_q, lead_d;
	logic [AVAIL_BITS-1:0]  avail_q, avail_d;  // bytes left for the content
	logic                   list_q, list_d;

	logic [AVAIL_BITS-1:0]  avail_m;
	logic [AVAIL_BITS-1:0]  avail_m1;
	logic [7:0]             b;
	logic [7:0]             short_len;
	logic [WID_W-1:0]       w_new;
	logic [WID_W-1:0]       w_cur;
	logic                   is_list_b;

	assign b         = item_s1.data_byte;
	assign avail_m   = item_s1.avail_bytes[AVAIL_BITS-1:0];
	assign avail_m1  = avail_m - AVAIL_BITS'(1);
	assign is_list_b = (b >= SHORT_LST_BASE);
	assign short_len = is_list_b ? (b - SHORT_LST_BASE) : (b - SHORT_STR_BASE);
	assign w_new     = long_width(b);
	assign w_cur     = long_width(hdr_q);

	always_comb begin
		phase_d = phase_q;
		hdr_d   = hdr_q;
		left_d  = left_q;
		acc_d   = acc_q;
		lead_d  = lead_q;
		avail_d = avail_q;
		list_d  = list_q;
		step    = '0;

		if (item_s1.start_req) begin
			phase_d = PH_IDLE;
			hdr_d   = b;
			acc_d   = '0;
			lead_d  = 1'b0;
			left_d  = '0;
			list_d  = is_list_b;
			if (avail_m == '0) begin
				avail_d   = '0;
				step.emit = 1'b1;
			end else begin
				avail_d = avail_m1;
				if (b < SHORT_STR_BASE) begin
					step.emit               = 1'b1;
					step.res.ok             = 1'b1;
					step.res.canonical_flag = 1'b1;
					step.res.payload_len    = LEN_W'(1);
					step.res.total_len      = LEN_W'(1);
				end else if (b <= SHORT_STR_LAST ||
					     (is_list_b && b <= SHORT_LST_LAST)) begin
					if (AVAIL_BITS'(short_len) > avail_m1) begin
						step.emit = 1'b1;
					end else if (!is_list_b && short_len == 8'd1) begin
						phase_d = PH_BYTE;
					end else begin
						step.emit               = 1'b1;
						step.res.ok             = 1'b1;
						step.res.list_flag      = is_list_b;
						step.res.canonical_flag = 1'b1;
						step.res.payload_offset = OFF_W'(1);
						step.res.payload_len    = LEN_W'(short_len);
						step.res.total_len      = LEN_W'(short_len) + LEN_W'(1);
					end
				end else begin
					if (avail_m1 < AVAIL_BITS'(w_new)) begin
						step.emit = 1'b1;
					end else begin
						left_d  = w_new;
						phase_d = PH_LEN;
						avail_d = avail_m1 - AVAIL_BITS'(w_new);
					end
				end
			end
		end else begin
			unique case (phase_q)
				PH_BYTE: begin
					phase_d                 = PH_IDLE;
					step.emit               = 1'b1;
					step.res.ok             = 1'b1;
					step.res.canonical_flag = (b >= SHORT_STR_BASE);
					step.res.payload_offset = OFF_W'(1);
					step.res.payload_len    = LEN_W'(1);
					step.res.total_len      = LEN_W'(2);
				end
				PH_LEN: begin
					if (left_q == w_cur) begin
						lead_d = (b != 8'd0);
					end
					acc_d  = {acc_q[ACC_W-9:0], b};
					left_d = left_q - WID_W'(1);
					if (left_d == '0) begin
						phase_d   = PH_IDLE;
						step.emit = 1'b1;
						if (acc_d <= ACC_W'(avail_q)) begin
							step.res.ok             = 1'b1;
							step.res.list_flag      = list_q;
							step.res.canonical_flag = lead_d && (acc_d > CANON_MIN_LONG);
							step.res.payload_offset = OFF_W'(w_cur) + OFF_W'(1);
							step.res.payload_len    = acc_d[LEN_W-1:0];
							step.res.total_len      = acc_d[LEN_W-1:0]
								+ LEN_W'(w_cur) + LEN_W'(1);
						end
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			hdr_q   <= '0;
			left_q  <= '0;
			acc_q   <= '0;
			lead_q  <= 1'b0;
			avail_q <= '0;
			list_q  <= 1'b0;
		end else if (step_en) begin
			phase_q <= phase_d;
			hdr_q   <= hdr_d;
			left_q  <= left_d;
			acc_q   <= acc_d;
			lead_q  <= lead_d;
			avail_q <= avail_d;
			list_q  <= list_d;
		end
	end

endmodule

`default_nettype wire

@@ src/rlphd_out_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rlphd_out_stage (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   step_en,
	input  wire rlphd_pkg::rlphd_step_t step,
	output logic                        advance,
	output logic                        hdr_valid,
	input  wire logic                   hdr_ready,
	output rlphd_pkg::rlphd_result_t    hdr_item
);
	import rlphd_pkg::*;

	logic load;

	// the result register frees up when empty or when taken this cycle
	assign advance = !hdr_valid || hdr_ready;
	assign load    = step_en && step.emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_valid <= 1'b0;
		end else if (advance) begin
			hdr_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			hdr_item <= step.res;
		end
	end

endmodule

`default_nettype wire

@@ src/rlp_item_header_decoder_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake               Payload
// byte      in   byte_valid/byte_ready   rlphd_byte_t   (one stream byte, start mark, avail)
// hdr       out  hdr_valid/hdr_ready     rlphd_result_t (one decoded header result)
//
// One item per cycle while hdr does not stall; the last byte of a header passes through
// the input register, then the decode step into the result register, where hdr_valid
// rises and the result can be taken.
// The header state advances once per byte in a single registered pass.
// A stall on hdr holds both registers; byte_ready drops only while both are full.
// arst_n clears the valid flags and the decode state to idle.
module rlp_item_header_decoder_core #(
	parameter int AVAIL_BITS = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   byte_valid,
	output logic                        byte_ready,
	input  wire rlphd_pkg::rlphd_byte_t byte_item,
	output logic                        hdr_valid,
	input  wire logic                   hdr_ready,
	output rlphd_pkg::rlphd_result_t    hdr_item
);
	import rlphd_pkg::*;

	logic        advance;
	logic        valid_s1;
	rlphd_byte_t item_s1;
	rlphd_step_t step;
	logic        step_en;

	// decode the held item only when its result slot is free
	assign step_en = valid_s1 && advance;

	rlphd_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	rlphd_decode #(
		.AVAIL_BITS (AVAIL_BITS)
	) u_dec (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.item_s1 (item_s1),
		.step    (step)
	);

	rlphd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (step_en),
		.step      (step),
		.advance   (advance),
		.hdr_valid (hdr_valid),
		.hdr_ready (hdr_ready),
		.hdr_item  (hdr_item)
	);

	// a failed item reports no header fields
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_valid && !hdr_item.ok |-> hdr_item.payload_len == '0 &&
			hdr_item.total_len == '0 && hdr_item.payload_offset == '0 &&
			!hdr_item.list_flag && !hdr_item.canonical_flag)
		else $error("failed result carries nonzero fields");

	// total length is header plus content
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_valid && hdr_item.ok |-> hdr_item.total_len ==
			hdr_item.payload_len + LEN_W'(hdr_item.payload_offset))
		else $error("total_len does not match offset plus payload_len");

	// an offset of zero only comes from a single-byte string
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_valid && hdr_item.ok && hdr_item.payload_offset == '0 |->
			hdr_item.payload_len == LEN_W'(1) && !hdr_item.list_flag)
		else $error("zero offset on a non single-byte item");

	// an accepted item lands in the input register
	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_ready |=> valid_s1)
		else $error("accepted item lost before decode");

endmodule

`default_nettype wire
